// ===== rtl/omnidirectional_point_to_pixel_macros.svh =====
// Assertion helpers for the projection block
`ifndef OMNIDIRECTIONAL_POINT_TO_PIXEL_MACROS_SVH
`define OMNIDIRECTIONAL_POINT_TO_PIXEL_MACROS_SVH

// same-cycle implication, disabled while in reset
`define OPTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define OPTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/optp_pkg.sv =====
`default_nettype none
package optp_pkg;

	localparam int MAX_TERMS = 16;

	// register indexes on the config port
	localparam logic [2:0] REG_CENTER_U = 3'd0;
	localparam logic [2:0] REG_CENTER_V = 3'd1;
	localparam logic [2:0] REG_AFF_VERT = 3'd2;
	localparam logic [2:0] REG_AFFINE_D = 3'd3;
	localparam logic [2:0] REG_AFFINE_E = 3'd4;
	localparam logic [2:0] REG_POLY_TERMS = 3'd5;

	localparam logic FUNC_COEF = 1'b0;
	localparam logic FUNC_PROJ = 1'b1;

	typedef struct packed {
		logic               func;
		logic [3:0]         coef_index;
		logic signed [47:0] coef_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pixel_u;
		logic signed [31:0] pixel_v;
		logic               clipped;
	} out_item_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_NORM = 9'b000000010,
		ST_SQ   = 9'b000000100,
		ST_SQRT = 9'b000001000,
		ST_DIV  = 9'b000010000,
		ST_CORD = 9'b000100000,
		ST_HORN = 9'b001000000,
		ST_PROJ = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	// atan(2^-i) in Q2.30, truncated
	function automatic logic [31:0] atan_tab(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// Q16.32 sum -> Q16.16 pixel, round half up, saturate; msb is the clip flag
	function automatic logic [32:0] to_pixel(input logic signed [52:0] s);
		logic signed [52:0] r;
		logic signed [36:0] p;
		logic [32:0] o;
		r = s + 53'sd32768;
		p = 37'(r >>> 16);
		if (p[36:31] == 6'b000000 || p[36:31] == 6'b111111) begin
			o = {1'b0, p[31:0]};
		end else if (p[36]) begin
			o = {1'b1, 32'h80000000};
		end else begin
			o = {1'b1, 32'h7FFFFFFF};
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/omnidirectional_point_to_pixel.sv =====
// Sequence: a coefficient write is taken in idle and the block stays idle; a point
//   on the axis goes straight to the result state; other points take two
//   normalizing shifts, two square roots, two divisions, the CORDIC steps, one
//   Horner step per term and the final products before the result state.
// Throughput: one request at a time; the sequencer holds in_ready low until done.
// Reset: arst_n clears control and config registers (vertical scale = 1.0,
//   poly_terms = 1); the coefficient table is undefined until written.
`default_nettype none
`include "omnidirectional_point_to_pixel_macros.svh"
module omnidirectional_point_to_pixel (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire optp_pkg::in_item_t in_req,
	output logic                  out_valid,
	input  wire                   out_ready,
	output optp_pkg::out_item_t   out_res,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [2:0]            cfg_index,
	input  wire  [31:0]           cfg_data
);
	import optp_pkg::*;

	// config registers
	logic signed [31:0] center_u_q, center_v_q, aff_vert_q, affine_d_q, affine_e_q;
	logic [4:0]         poly_terms_q;

	// coefficient table, one read port driven by the Horner index
	logic signed [47:0] coef_q [MAX_TERMS];

	state_t state_q;
	logic   pass_q;        // 0: direction ratios, 1: angle
	logic   axis_q;        // point on the optical axis
	logic   sx_q, sy_q, zpos_q;
	logic [31:0] ux_q, uy_q, uz_q;
	logic [31:0] ax_q, ay_q, az_q, m_q;
	logic [4:0]  cnt_q;
	logic [3:0]  idx_q;
	logic        mph_q;    // multiplier phase
	logic [63:0] sq_q, v_q, r_q;
	logic [31:0] n_q;
	logic [32:0] rem_q;
	logic [30:0] q_q;
	logic        dsel_q;
	logic signed [31:0] qu_q, qv_q;
	logic signed [51:0] cx_q, cy_q;
	logic signed [32:0] ang_q;
	logic signed [47:0] rho_q;
	logic signed [48:0] uu_q, vv_q;
	logic signed [50:0] t1_q, t2_q, t3_q;
	logic [63:0] p0_q;
	logic        out_valid_q;
	out_item_t   out_res_q;

	logic in_acc, cfg_acc;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// magnitudes of the incoming point
	logic [31:0] in_ux, in_uy, in_uz;
	assign in_ux = in_req.point_x[31] ? 32'(-in_req.point_x) : in_req.point_x;
	assign in_uy = in_req.point_y[31] ? 32'(-in_req.point_y) : in_req.point_y;
	assign in_uz = in_req.point_z[31] ? 32'(-in_req.point_z) : in_req.point_z;

	logic [31:0] mxy, mxyz;
	assign mxy  = (ux_q > uy_q) ? ux_q : uy_q;
	assign mxyz = (uz_q > mxy) ? uz_q : mxy;

	// square unit, 32x32
	logic [31:0] sq_op;
	logic [63:0] sq_prod;
	assign sq_op   = cnt_q[0] ? ay_q : ax_q;
	assign sq_prod = sq_op * sq_op;

	// integer square root, one result bit per cycle
	logic [63:0] sr_bit, sr_trial, sr_v_nx, sr_r_nx;
	always_comb begin
		sr_bit   = 64'd1 << (6'd62 - {cnt_q, 1'b0});
		sr_trial = r_q + sr_bit;
		if (v_q >= sr_trial) begin
			sr_v_nx = v_q - sr_trial;
			sr_r_nx = (r_q >> 1) + sr_bit;
		end else begin
			sr_v_nx = v_q;
			sr_r_nx = r_q >> 1;
		end
	end

	// restoring division, quotient bit per cycle
	logic [32:0] dv_trial, dv_rem_nx;
	logic        dv_ge;
	logic [30:0] dv_q_nx;
	always_comb begin
		dv_trial  = (cnt_q == 5'd0) ? rem_q : {rem_q[31:0], 1'b0};
		dv_ge     = dv_trial >= {1'b0, n_q};
		dv_rem_nx = dv_ge ? dv_trial - {1'b0, n_q} : dv_trial;
		dv_q_nx   = {q_q[29:0], dv_ge};
	end

	// CORDIC vectoring step
	logic signed [51:0] cd_dx, cd_dy, cx_nx, cy_nx;
	logic signed [32:0] ang_nx;
	logic signed [32:0] cd_ang;
	always_comb begin
		cd_dx  = cy_q >>> cnt_q;
		cd_dy  = cx_q >>> cnt_q;
		cd_ang = 33'(signed'({1'b0, atan_tab(cnt_q)}));
		if (!cy_q[51]) begin
			cx_nx  = cx_q + cd_dx;
			cy_nx  = cy_q - cd_dy;
			ang_nx = ang_q + cd_ang;
		end else begin
			cx_nx  = cx_q - cd_dx;
			cy_nx  = cy_q + cd_dy;
			ang_nx = ang_q - cd_ang;
		end
	end

	// shared Q2.30 multiplier: |a|*|b| >> 30 built from two 48x16 partial products, low half first
	logic signed [48:0] mul_a;
	logic signed [32:0] mul_b;
	always_comb begin
		mul_a = 49'(rho_q);
		mul_b = ang_q;
		if (state_q == ST_PROJ) begin
			case (cnt_q)
				5'd0: begin mul_a = 49'(rho_q); mul_b = 33'(qu_q); end
				5'd1: begin mul_a = 49'(rho_q); mul_b = 33'(qv_q); end
				5'd2: begin mul_a = vv_q; mul_b = 33'(affine_e_q); end
				5'd3: begin mul_a = uu_q; mul_b = 33'(affine_d_q); end
				default: begin mul_a = vv_q; mul_b = 33'(aff_vert_q); end
			endcase
		end
	end

	logic [47:0] mu_a;
	logic [31:0] mu_b;
	logic [15:0] mu_b16;
	logic [63:0] mu_prod;
	logic [79:0] mu_full;
	logic [49:0] mu_r;
	logic        mu_neg;
	logic signed [50:0] mres;
	always_comb begin
		mu_a    = 48'(mul_a[48] ? -mul_a : mul_a);
		mu_b    = 32'(mul_b[32] ? -mul_b : mul_b);
		mu_neg  = mul_a[48] ^ mul_b[32];
		mu_b16  = mph_q ? mu_b[31:16] : mu_b[15:0];
		mu_prod = mu_a * mu_b16;
		mu_full = {mu_prod, 16'd0} + {16'd0, p0_q};
		mu_r    = mu_full[79:30];
		mres    = mu_neg ? -signed'({1'b0, mu_r}) : signed'({1'b0, mu_r});
	end

	// Horner accumulate with 48-bit saturation
	logic signed [51:0] hs;
	logic signed [47:0] hs_sat;
	always_comb begin
		hs = 52'(mres) + 52'(coef_q[idx_q]);
		if (hs[51:47] == 5'b00000 || hs[51:47] == 5'b11111) begin
			hs_sat = hs[47:0];
		end else if (hs[51]) begin
			hs_sat = {1'b1, 47'd0};
		end else begin
			hs_sat = {1'b0, {47{1'b1}}};
		end
	end

	// output sums in Q16.32
	logic signed [52:0] sum_u, sum_v;
	logic [32:0] pix_u, pix_v;
	assign sum_u = 53'(uu_q) + 53'(t1_q) + 53'(signed'({center_u_q, 16'd0}));
	assign sum_v = 53'(t2_q) + 53'(t3_q) + 53'(signed'({center_v_q, 16'd0}));
	assign pix_u = to_pixel(sum_u);
	assign pix_v = to_pixel(sum_v);

	logic [4:0] terms;
	assign terms = (poly_terms_q > 5'(MAX_TERMS)) ? 5'(MAX_TERMS) : poly_terms_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_u_q   <= '0;
			center_v_q   <= '0;
			aff_vert_q   <= 32'sh40000000;
			affine_d_q   <= '0;
			affine_e_q   <= '0;
			poly_terms_q <= 5'd1;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				REG_CENTER_U:   center_u_q   <= cfg_data;
				REG_CENTER_V:   center_v_q   <= cfg_data;
				REG_AFF_VERT:   aff_vert_q   <= cfg_data;
				REG_AFFINE_D:   affine_d_q   <= cfg_data;
				REG_AFFINE_E:   affine_e_q   <= cfg_data;
				REG_POLY_TERMS: poly_terms_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// coefficient table
	always_ff @(posedge clk) begin
		if (in_acc && in_req.func == FUNC_COEF) begin
			coef_q[in_req.coef_index] <= in_req.coef_value;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			mph_q       <= 1'b0;
			pass_q      <= 1'b0;
			dsel_q      <= 1'b0;
			idx_q       <= '0;
			axis_q      <= 1'b0;
		end else begin
			// the result state reloads the slot itself
			if (out_valid_q && out_ready && state_q != ST_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_req.func == FUNC_PROJ) begin
						axis_q <= (in_ux == 32'd0) && (in_uy == 32'd0);
						pass_q <= 1'b0;
						state_q <= ((in_ux == 32'd0) && (in_uy == 32'd0)) ? ST_OUT : ST_NORM;
					end
				end
				ST_NORM: begin
					if (m_q[31:30] != 2'b00) begin
						cnt_q   <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[0]) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						cnt_q   <= '0;
						dsel_q  <= 1'b0;
						state_q <= pass_q ? ST_CORD : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						cnt_q <= '0;
						if (dsel_q) begin
							pass_q  <= 1'b1;
							state_q <= ST_NORM;
						end else begin
							dsel_q <= 1'b1;
						end
					end
				end
				ST_CORD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						cnt_q <= '0;
						mph_q <= 1'b0;
						idx_q <= 4'(terms - 5'd1);
						state_q <= (terms == 5'd0) ? ST_PROJ : ST_HORN;
					end
				end
				ST_HORN: begin
					mph_q <= ~mph_q;
					if (mph_q) begin
						idx_q <= idx_q - 4'd1;
						if (idx_q == 4'd0) state_q <= ST_PROJ;
					end
				end
				ST_PROJ: begin
					mph_q <= ~mph_q;
					if (mph_q) begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'd4) begin
							cnt_q   <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sx_q   <= in_req.point_x[31];
				sy_q   <= in_req.point_y[31];
				zpos_q <= !in_req.point_z[31] && (in_uz != 32'd0);
				ux_q   <= in_ux;
				uy_q   <= in_uy;
				uz_q   <= in_uz;
				ax_q   <= in_ux;
				ay_q   <= in_uy;
				az_q   <= in_uz;
				m_q    <= (in_ux > in_uy) ? in_ux : in_uy;
				rho_q  <= '0;
			end
			ST_NORM: begin
				if (m_q[31:30] == 2'b00) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
					az_q <= az_q << 1;
					m_q  <= m_q << 1;
				end
			end
			ST_SQ: begin
				if (cnt_q[0]) begin
					v_q <= sq_q + sq_prod;
					r_q <= '0;
				end else begin
					sq_q <= sq_prod;
				end
			end
			ST_SQRT: begin
				v_q <= sr_v_nx;
				r_q <= sr_r_nx;
				if (cnt_q == 5'd31) begin
					n_q   <= sr_r_nx[31:0];
					rem_q <= {1'b0, ax_q};
					cx_q  <= 52'(signed'({1'b0, sr_r_nx[31:0], 16'd0}));
					cy_q  <= zpos_q ? -52'(signed'({1'b0, az_q, 16'd0}))
					               :  52'(signed'({1'b0, az_q, 16'd0}));
					ang_q <= '0;
				end
			end
			ST_DIV: begin
				q_q <= dv_q_nx;
				if (cnt_q == 5'd30) begin
					if (dsel_q) begin
						rem_q <= dv_rem_nx;
						qv_q <= sy_q ? -32'(signed'({1'b0, dv_q_nx})) : 32'(signed'({1'b0, dv_q_nx}));
						ax_q <= ux_q;
						ay_q <= uy_q;
						az_q <= uz_q;
						m_q  <= mxyz;
					end else begin
						qu_q  <= sx_q ? -32'(signed'({1'b0, dv_q_nx})) : 32'(signed'({1'b0, dv_q_nx}));
						rem_q <= {1'b0, ay_q};
					end
				end else begin
					rem_q <= dv_rem_nx;
				end
			end
			ST_CORD: begin
				cx_q  <= cx_nx;
				cy_q  <= cy_nx;
				ang_q <= ang_nx;
			end
			ST_HORN: begin
				if (mph_q) rho_q <= hs_sat;
				else       p0_q  <= mu_prod;
			end
			ST_PROJ: begin
				if (!mph_q) begin
					p0_q <= mu_prod;
				end else begin
					case (cnt_q)
						5'd0: uu_q <= 49'(mres);
						5'd1: vv_q <= 49'(mres);
						5'd2: t1_q <= mres;
						5'd3: t2_q <= mres;
						default: t3_q <= mres;
					endcase
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					if (axis_q) begin
						out_res_q.pixel_u <= center_u_q;
						out_res_q.pixel_v <= center_v_q;
						out_res_q.clipped <= 1'b0;
					end else begin
						out_res_q.pixel_u <= pix_u[31:0];
						out_res_q.pixel_v <= pix_v[31:0];
						out_res_q.clipped <= pix_u[32] | pix_v[32];
					end
				end
			end
			default: ;
		endcase
	end

	// a projection request always leaves idle
	`OPTP_ASSERT_NXT(a_proj_busy, in_acc && in_req.func == FUNC_PROJ, state_q != ST_IDLE, "projection request did not start")
	// divisor never zero during the ratio divisions
	`OPTP_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, n_q != 32'd0, "zero divisor in ratio division")
	// a free output slot in the result state is filled next cycle
	`OPTP_ASSERT_NXT(a_out_load, state_q == ST_OUT && !out_valid_q, out_valid_q && state_q == ST_IDLE, "result not delivered")

endmodule
`default_nettype wire

// ===== test/pixel_projection_checker.sv =====
`default_nettype none
module pixel_projection_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_ready,
	input  wire optp_pkg::in_item_t  in_req,
	input  wire                 out_valid,
	input  wire                 out_ready,
	input  wire optp_pkg::out_item_t out_res,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire [2:0]           cfg_index,
	input  wire [31:0]          cfg_data,
	output int                  errors,
	output int                  pending
);
	import optp_pkg::*;

	longint    coef_mem [MAX_TERMS];
	longint    cen_u, cen_v, aff_c, aff_d, aff_e;
	int        term_count;
	out_item_t expected_pixels[$];

	// atan(2^-i), Q2.30, truncated
	longint atan_q30 [32] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
		64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
		64'h00000001, 64'h00000000};

	assign pending = expected_pixels.size();

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	// magnitude product >> 30, sign applied after
	function automatic longint scale_q30(longint a, longint b);
		logic [127:0] p;
		longint r;
		p = 128'(magnitude(a)) * 128'(magnitude(b));
		r = longint'(p >> 30);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint clamp48(longint v);
		if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
		if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
		return v;
	endfunction

	function automatic int lead_shift(longint unsigned m);
		int k;
		k = 0;
		if (m == 0) return 0;
		while (m < 64'd1 << 30) begin
			m = m << 1;
			k++;
		end
		return k;
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint round_pixel(longint s, ref logic clip);
		longint p;
		p = (s + 64'sd32768) >>> 16;
		if (p > 64'sd2147483647) begin
			clip = 1'b1;
			return 64'sd2147483647;
		end
		if (p < -64'sd2147483648) begin
			clip = 1'b1;
			return -64'sd2147483648;
		end
		return p;
	endfunction

	function automatic out_item_t project_point(in_item_t it);
		out_item_t r;
		longint x, y, z, qu, qv, cx, cy, ang, rho, uu, vv, pu, pv, dx, dy;
		longint unsigned ux, uy, uz, m, xs, ys, n;
		int k, terms;
		logic clip;
		clip = 1'b0;
		x = it.point_x;
		y = it.point_y;
		z = it.point_z;
		ux = magnitude(x);
		uy = magnitude(y);
		uz = magnitude(z);
		if (ux == 0 && uy == 0) begin
			pu = cen_u;
			pv = cen_v;
		end else begin
			m = ux > uy ? ux : uy;
			k = lead_shift(m);
			xs = ux << k;
			ys = uy << k;
			n = root64(xs * xs + ys * ys);
			qu = longint'((xs << 30) / n);
			if (x < 0) qu = -qu;
			qv = longint'((ys << 30) / n);
			if (y < 0) qv = -qv;
			// common scale with z for the angle
			if (uz > m) m = uz;
			k = lead_shift(m);
			xs = ux << k;
			ys = uy << k;
			cx = longint'(root64(xs * xs + ys * ys) << 16);
			cy = longint'((uz << k) << 16);
			if (z > 0) cy = -cy;
			ang = 0;
			for (int i = 0; i < 32; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx += dx;
					cy -= dy;
					ang += atan_q30[i];
				end else begin
					cx -= dx;
					cy += dy;
					ang -= atan_q30[i];
				end
			end
			terms = term_count > MAX_TERMS ? MAX_TERMS : term_count;
			rho = 0;
			for (int i = terms; i > 0; i--)
				rho = clamp48(scale_q30(rho, ang) + coef_mem[i - 1]);
			uu = scale_q30(rho, qu);
			vv = scale_q30(rho, qv);
			pu = round_pixel(uu + scale_q30(vv, aff_e) + cen_u * 65536, clip);
			pv = round_pixel(scale_q30(uu, aff_d) + scale_q30(vv, aff_c) + cen_v * 65536,
				clip);
		end
		r.pixel_u = pu[31:0];
		r.pixel_v = pv[31:0];
		r.clipped = clip;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			cen_u = 0;
			cen_v = 0;
			aff_c = 64'sd1 << 30;
			aff_d = 0;
			aff_e = 0;
			term_count = 1;
			errors = 0;
			foreach (coef_mem[i]) coef_mem[i] = 0;
			expected_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CENTER_U:   cen_u = longint'($signed(cfg_data));
					REG_CENTER_V:   cen_v = longint'($signed(cfg_data));
					REG_AFF_VERT:   aff_c = longint'($signed(cfg_data));
					REG_AFFINE_D:   aff_d = longint'($signed(cfg_data));
					REG_AFFINE_E:   aff_e = longint'($signed(cfg_data));
					REG_POLY_TERMS: term_count = int'(cfg_data[4:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_req.func == FUNC_COEF)
					coef_mem[in_req.coef_index] = longint'(in_req.coef_value);
				else
					expected_pixels.insert(expected_pixels.size(), project_point(in_req));
			end
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_pixels.pop_front();
					if (out_res.pixel_u !== want.pixel_u)
						report_mismatch($sformatf("pixel_u %h, want %h",
							out_res.pixel_u, want.pixel_u));
					if (out_res.pixel_v !== want.pixel_v)
						report_mismatch($sformatf("pixel_v %h, want %h",
							out_res.pixel_v, want.pixel_v));
					if (out_res.clipped !== want.clipped)
						report_mismatch($sformatf("clipped %b, want %b",
							out_res.clipped, want.clipped));
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
	import optp_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_req;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_res;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int        errors;
	int        pending;

	// receiver controls: no idling in the final phase, one long hold-off on request
	logic quiet;
	logic hold_off;
	int   idle_cycles;

	omnidirectional_point_to_pixel u_dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .in_req,
		.out_valid, .out_ready, .out_res,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	pixel_projection_checker u_check (
		.clk, .arst_n,
		.in_valid, .in_ready, .in_req,
		.out_valid, .out_ready, .out_res,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors, .pending
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// random coordinate: full range, extreme, small, or zero, so both axes and the
	// on-axis case get visited
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0:       return 32'h0;
			1, 2:    return $urandom;
			3:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
		endcase
	endfunction

	function automatic logic [47:0] pick_coef();
		logic [63:0] r;
		r = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0) return r[47:0];
		// plausible lens coefficients: a few hundred pixels or less
		return 48'($signed(r[41:0]) >>> $urandom_range(0, 12));
	endfunction

	task automatic send_req(in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_req <= it;
		do @(posedge clk); while (!in_ready);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_coef(int idx, logic [47:0] v);
		in_item_t it;
		it = '0;
		it.func = FUNC_COEF;
		it.coef_index = idx[3:0];
		it.coef_value = v;
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.point_z = $urandom;
		send_req(it);
	endtask

	task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_item_t it;
		it.func = FUNC_PROJ;
		it.coef_index = 4'($urandom);
		it.coef_value = pick_coef();
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		send_req(it);
	endtask

	// valid stays up across back-to-back writes; the caller drops it
	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic setup_regs(logic [31:0] cu, logic [31:0] cv, logic [31:0] c,
		logic [31:0] d, logic [31:0] e, logic [31:0] terms);
		write_reg(REG_CENTER_U, cu);
		write_reg(REG_CENTER_V, cv);
		write_reg(REG_AFF_VERT, c);
		write_reg(REG_AFFINE_D, d);
		write_reg(REG_AFFINE_E, e);
		write_reg(REG_POLY_TERMS, terms);
		cfg_valid <= 1'b0;
	endtask

	// drain: stop offering, wait out every result, then let a coefficient write settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_items(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0)
				load_coef($urandom_range(0, 15), pick_coef());
			else
				project(pick_coord(), pick_coord(), pick_coord());
		end
	endtask

	// receiver: random ready bursts, one long hold-off, steady ready when quiet
	initial begin
		int len;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if (hold_off) begin
				out_ready <= 1'b0;
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				len = $urandom_range(1, 13);
				out_ready <= $urandom_range(0, 2) != 0;
				repeat (len) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no request moving anywhere
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= 20000) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_off = 1'b0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole coefficient table before any projection reads it
		load_coef(0, 48'h7FFF_FFFF_FFFF);
		load_coef(1, 48'h8000_0000_0000);
		for (int i = 2; i < MAX_TERMS; i++) load_coef(i, pick_coef());

		// directed points at reset config (one term, constant rho)
		project(32'h0, 32'h0, 32'h7FFFFFFF);          // on the axis
		project(32'h7FFFFFFF, 32'h0, 32'h0);
		project(32'h80000000, 32'h80000000, 32'h80000000);
		project(32'h0, 32'h7FFFFFFF, 32'h80000000);
		project(32'h1, 32'h0, 32'h7FFFFFFF);
		project(32'hFFFFFFFF, 32'h1, 32'h0);
		project(32'h00010000, 32'hFFFF0000, 32'h00010000);
		load_coef(0, 48'h0000_0000_0000);
		project(32'h00050000, 32'h00030000, 32'hFFFE0000);
		drain();

		setup_regs(32'h01400000, 32'h00F00000, 32'h40000000, 32'h0, 32'h0, 16);
		random_items(75);
		drain();

		// extremes, zero terms forces rho to zero
		setup_regs(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 0);
		project(32'h0, 32'h0, 32'h12345678);
		random_items(20);
		drain();

		setup_regs($urandom, $urandom, $urandom, $urandom, $urandom, 31);
		hold_off = 1'b1;
		random_items(75);
		drain();

		setup_regs($urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom_range(1, 16));
		random_items(75);
		drain();

		setup_regs(32'h01000000, 32'h00C00000, 32'h3F000000, 32'h00100000,
			32'hFFF00000, 5);
		random_items(60);
		drain();

		quiet = 1'b1;
		setup_regs($urandom, $urandom, $urandom_range(32'h30000000, 32'h50000000),
			$urandom_range(0, 32'h00FFFFFF), $urandom_range(0, 32'h00FFFFFF),
			$urandom_range(1, 16));
		random_items(75);
		drain();

		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
